// ===== design/fds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants of the disk request scheduler
// Default sizes, the controller state type and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TRACK_BITS  = 12;
    localparam int OP_BITS         = 16;

    // Input item kinds.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DIR,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add;
        logic nogrant;
        logic fetch;
        logic spread;
        logic dir;
        logic scan;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pending;
        logic ud_empty;
        logic last;
    } t_status;

endpackage

// ===== design/fds_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_req_if / fds_grant_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface fds_req_if #(
    parameter int TRACK_BITS = 12
);
    import fds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [TRACK_BITS-1:0] track;
    logic [OP_BITS-1:0]    op_index;
    logic [TRACK_BITS-1:0] head_track;

    modport source (output valid, kind, track, op_index, head_track, input ready);
    modport sink   (input valid, kind, track, op_index, head_track, output ready);
endinterface

interface fds_grant_if #(
    parameter int TRACK_BITS = 12
);
    import fds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  grant_valid;
    logic [TRACK_BITS-1:0] grant_track;
    logic [OP_BITS-1:0]    grant_op_index;
    logic                  moving_up;
    logic                  still_pending;
    logic                  add_rejected;

    modport source (output valid, grant_valid, grant_track, grant_op_index, moving_up,
                    still_pending, add_rejected, input ready);
    modport sink   (input valid, grant_valid, grant_track, grant_op_index, moving_up,
                    still_pending, add_rejected, output ready);
endinterface

// ===== design/fds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_ctrl: scheduler controller
// Answers adds while idle and sequences a fetch through distribution, direction
// update, scan and grant, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module fds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    input  logic             i_out_ready,
    input  fds_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output fds_pkg::t_cmd    o_cmd,
    output fds_pkg::t_state  o_state
);
    import fds_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = o_in_ready && i_in_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_kind == KIND_ADD) begin
                        o_cmd.add   = 1'b1;
                        n_out_valid = 1'b1;
                    end else if (!i_status.pending) begin
                        o_cmd.nogrant = 1'b1;
                        n_out_valid   = 1'b1;
                    end else begin
                        o_cmd.fetch = 1'b1;
                        n_state     = i_status.ud_empty ? ST_DIST : ST_DIR;
                    end
                end
            end
            ST_DIST: begin
                o_cmd.spread = 1'b1;
                if (i_status.last) begin
                    n_state = ST_DIR;
                end
            end
            ST_DIR: begin
                o_cmd.dir = 1'b1;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin   = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;
endmodule

// ===== design/fds_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds_datapath: request stores, nearest-track scan and result register
// Holds the hold, upward and downward stores, walks them one entry per
// cycle under controller commands and registers the result item.
// ----------------------------------------------------------------------------
module fds_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fds_pkg::t_cmd              i_cmd,
    input  logic [TRACK_BITS-1:0]      i_track,
    input  logic [fds_pkg::OP_BITS-1:0] i_op_index,
    input  logic [TRACK_BITS-1:0]      i_head_track,
    output fds_pkg::t_status           o_status,
    output logic                       o_grant_valid,
    output logic [TRACK_BITS-1:0]      o_grant_track,
    output logic [fds_pkg::OP_BITS-1:0] o_grant_op_index,
    output logic                       o_moving_up,
    output logic                       o_still_pending,
    output logic                       o_add_rejected
);
    import fds_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Hold store is kept packed with a count; up and down use valid bits.
    logic [TRACK_BITS-1:0]  r_hold_trk [QUEUE_DEPTH];
    logic [OP_BITS-1:0]     r_hold_op  [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]  r_up_trk   [QUEUE_DEPTH];
    logic [OP_BITS-1:0]     r_up_op    [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]  r_dn_trk   [QUEUE_DEPTH];
    logic [OP_BITS-1:0]     r_dn_op    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_up_v, n_up_v;
    logic [QUEUE_DEPTH-1:0] r_dn_v, n_dn_v;
    logic [CW-1:0]          r_hold_cnt;
    logic                   r_sweep_up;
    logic [IW-1:0]          r_idx;
    logic [TRACK_BITS-1:0]  r_head;

    // Best candidate of the running scan.
    logic                   r_found;
    logic [IW-1:0]          r_best;
    logic [TRACK_BITS-1:0]  r_best_trk;
    logic [OP_BITS-1:0]     r_best_op;
    logic [TRACK_BITS-1:0]  r_best_d;

    logic                   w_full;
    logic                   w_last;
    logic [TRACK_BITS-1:0]  w_hold_t;
    logic                   w_hold_in;
    logic                   w_act_v;
    logic [TRACK_BITS-1:0]  w_act_t;
    logic [OP_BITS-1:0]     w_act_o;
    logic [TRACK_BITS-1:0]  w_d;
    logic                   w_better;

    assign w_full    = (r_hold_cnt == CW'(QUEUE_DEPTH));
    assign w_last    = (r_idx == IW'(QUEUE_DEPTH - 1));
    assign w_hold_t  = r_hold_trk[r_idx];
    assign w_hold_in = (CW'(r_idx) < r_hold_cnt);

    // Current entry of the active store and its distance to the head.
    assign w_act_v  = r_sweep_up ? r_up_v[r_idx] : r_dn_v[r_idx];
    assign w_act_t  = r_sweep_up ? r_up_trk[r_idx] : r_dn_trk[r_idx];
    assign w_act_o  = r_sweep_up ? r_up_op[r_idx] : r_dn_op[r_idx];
    assign w_d      = (w_act_t >= r_head) ? (w_act_t - r_head) : (r_head - w_act_t);
    assign w_better = w_act_v && (!r_found || (w_d < r_best_d) ||
                      ((w_d == r_best_d) && (w_act_o < r_best_op)));

    // Valid bits after the grant removes its entry.
    always_comb begin
        n_up_v = r_up_v;
        n_dn_v = r_dn_v;
        if (r_sweep_up) begin
            n_up_v[r_best] = 1'b0;
        end else begin
            n_dn_v[r_best] = 1'b0;
        end
    end

    // Store payloads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !w_full) begin
            r_hold_trk[r_hold_cnt[IW-1:0]] <= i_track;
            r_hold_op[r_hold_cnt[IW-1:0]]  <= i_op_index;
        end
        if (i_cmd.spread) begin
            r_up_trk[r_idx] <= w_hold_t;
            r_up_op[r_idx]  <= r_hold_op[r_idx];
            r_dn_trk[r_idx] <= w_hold_t;
            r_dn_op[r_idx]  <= r_hold_op[r_idx];
        end
    end

    // Control state: counts, valid bits, direction and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cnt <= '0;
            r_up_v     <= '0;
            r_dn_v     <= '0;
            r_sweep_up <= 1'b1;
            r_idx      <= '0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.add && !w_full) begin
                r_hold_cnt <= r_hold_cnt + CW'(1);
            end
            if (i_cmd.fetch) begin
                r_idx <= '0;
            end
            if (i_cmd.spread) begin
                r_up_v[r_idx] <= w_hold_in && ((w_hold_t > r_head) ||
                                 ((w_hold_t == r_head) && r_sweep_up));
                r_dn_v[r_idx] <= w_hold_in && ((w_hold_t < r_head) ||
                                 ((w_hold_t == r_head) && !r_sweep_up));
                r_idx <= w_last ? '0 : r_idx + IW'(1);
                if (w_last) begin
                    r_hold_cnt <= '0;
                end
            end
            if (i_cmd.dir) begin
                r_found <= 1'b0;
                if (r_sweep_up && (r_up_v == '0)) begin
                    r_sweep_up <= 1'b0;
                end else if (!r_sweep_up && (r_dn_v == '0)) begin
                    r_sweep_up <= 1'b1;
                end
            end
            if (i_cmd.scan) begin
                r_idx <= w_last ? '0 : r_idx + IW'(1);
                if (w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.fin && r_found) begin
                r_up_v <= n_up_v;
                r_dn_v <= n_dn_v;
            end
        end
    end

    // Head and best-candidate payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_head <= i_head_track;
        end
        if (i_cmd.scan && w_better) begin
            r_best     <= r_idx;
            r_best_trk <= w_act_t;
            r_best_op  <= w_act_o;
            r_best_d   <= w_d;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            o_grant_valid    <= 1'b0;
            o_grant_track    <= '0;
            o_grant_op_index <= '0;
            o_moving_up      <= r_sweep_up;
            o_still_pending  <= 1'b1;
            o_add_rejected   <= w_full;
        end else if (i_cmd.nogrant) begin
            o_grant_valid    <= 1'b0;
            o_grant_track    <= '0;
            o_grant_op_index <= '0;
            o_moving_up      <= r_sweep_up;
            o_still_pending  <= 1'b0;
            o_add_rejected   <= 1'b0;
        end else if (i_cmd.fin) begin
            o_grant_valid    <= r_found;
            o_grant_track    <= r_found ? r_best_trk : '0;
            o_grant_op_index <= r_found ? r_best_op : '0;
            o_moving_up      <= r_sweep_up;
            o_still_pending  <= (r_hold_cnt != '0) ||
                                (r_found ? ((n_up_v | n_dn_v) != '0)
                                         : ((r_up_v | r_dn_v) != '0));
            o_add_rejected   <= 1'b0;
        end
    end

    assign o_status.pending  = (r_hold_cnt != '0) || (r_up_v != '0) || (r_dn_v != '0);
    assign o_status.ud_empty = (r_up_v == '0) && (r_dn_v == '0);
    assign o_status.last     = w_last;
endmodule

// ===== design/flook_disk_scheduler.sv =====
`timescale 1ns / 1ps
// An add, or a fetch with nothing pending, is answered from the idle state;
// any other fetch first walks the hold store into the up and down stores when
// both are empty, then updates the direction, scans one store and answers.
// The walks cover one entry per cycle; requests are taken only while idle.
// Synchronous active-low reset empties all stores and sets direction up.
// ----------------------------------------------------------------------------
// flook_disk_scheduler: FLOOK disk request scheduler
// Collects requests and grants, on each fetch, the nearest request in the
// current sweep direction.
// ----------------------------------------------------------------------------
module flook_disk_scheduler #(
    parameter int QUEUE_DEPTH = fds_pkg::DEF_QUEUE_DEPTH,
    parameter int TRACK_BITS  = fds_pkg::DEF_TRACK_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fds_req_if.sink      i_req,
    fds_grant_if.source  o_grant
);
    import fds_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_state  w_state;
    logic    w_out_valid;

    fds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_kind   (i_req.kind),
        .i_out_ready (o_grant.ready),
        .i_status    (w_status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    fds_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_track          (i_req.track),
        .i_op_index       (i_req.op_index),
        .i_head_track     (i_req.head_track),
        .o_status         (w_status),
        .o_grant_valid    (o_grant.grant_valid),
        .o_grant_track    (o_grant.grant_track),
        .o_grant_op_index (o_grant.grant_op_index),
        .o_moving_up      (o_grant.moving_up),
        .o_still_pending  (o_grant.still_pending),
        .o_add_rejected   (o_grant.add_rejected)
    );

    assign o_grant.valid = w_out_valid;

    // No result is shown while a fetch is being worked on.
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state != ST_IDLE) |-> !w_out_valid)
        else $error("result valid while a fetch is in progress");

    // The scan only runs when a directional store holds a request.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_SCAN) |-> !w_status.ud_empty)
        else $error("scan started with empty directional stores");

    // A fetch that found work always ends in a grant.
    a_fin_grants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |=> (w_out_valid && o_grant.grant_valid))
        else $error("fetch with pending requests gave no grant");

    // An add result always reports pending requests.
    a_add_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.add |=> o_grant.still_pending)
        else $error("add result reports nothing pending");
endmodule
